// ----- hdl/http_request_line_parser_top_assert.svh -----
// Assertion macros for the HTTP request line parser checker.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define HRLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hrlp_pkg.sv -----
// Package for the HTTP request line parser: types, character constants and
// the string lookup functions. No dependencies.
`default_nettype none

package hrlp_pkg;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Index of the last character of each method string.
  localparam logic [2:0] GET_LAST  = 3'd3;
  localparam logic [2:0] POST_LAST = 3'd4;
  // Number of characters of "HTTP/1." before the minor version digit.
  localparam logic [2:0] VER_PREFIX_LEN = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_METHOD     = 3'd1,
    PH_PATH_FIRST = 3'd2,
    PH_PATH       = 3'd3,
    PH_VERSION    = 3'd4,
    PH_DONE       = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_METHOD  = 2'd1,
    ST_BAD_PATH    = 2'd2,
    ST_BAD_VERSION = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_line;
  } item_t;

  typedef struct packed {
    logic       path_valid;
    logic [7:0] path_byte;
    logic       done_res;
    logic [1:0] status;
    logic       method;
    logic       version;
  } result_t;

  // Expected method character at a given position.
  function automatic logic [7:0] method_char(input logic is_post, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (is_post) begin
      unique case (pos)
        3'd0: c = CH_P;
        3'd1: c = CH_O;
        3'd2: c = CH_S;
        3'd3: c = CH_T;
        3'd4: c = CH_SPACE;
        default: c = 8'h00;
      endcase
    end else begin
      unique case (pos[1:0])
        2'd0: c = CH_G;
        2'd1: c = CH_E;
        2'd2: c = CH_T;
        2'd3: c = CH_SPACE;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // Expected character of the "HTTP/1." prefix at a given position.
  function automatic logic [7:0] ver_char(input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (pos)
      3'd0: c = CH_H;
      3'd1: c = CH_T;
      3'd2: c = CH_T;
      3'd3: c = CH_P;
      3'd4: c = CH_SLASH;
      3'd5: c = CH_ONE;
      3'd6: c = CH_DOT;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hrlp_stream_if.sv -----
// Valid/ready channel interfaces for the HTTP request line parser.
// No dependencies.
`default_nettype none

interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_line;

  modport source (output valid, output data_byte, output start_line, input ready);
  modport sink   (input valid, input data_byte, input start_line, output ready);
endinterface

interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic       path_valid;
  logic [7:0] path_byte;
  logic       done_res;
  logic [1:0] status;
  logic       method;
  logic       version;

  modport source (output valid, output path_valid, output path_byte, output done_res,
                  output status, output method, output version, input ready);
  modport sink   (input valid, input path_valid, input path_byte, input done_res,
                  input status, input method, input version, output ready);
endinterface

`default_nettype wire

// ----- hdl/http_request_line_parser_top.sv -----
// Top level of the HTTP request line parser: input register, parser core,
// result register. Depends on hrlp_pkg, hrlp_stream_if and the hrlp_* stages.
//
//   Channel   Direction  Handshake        Payload
//   in_if     sink       valid / ready    data_byte, start_line
//   out_if    source     valid / ready    path_valid, path_byte, done_res,
//                                         status, method, version
//   cfg       write      cfg_we           cfg_wdata (check_path)
//
// A byte passes via the input register into the result register, which offers
// its result; new bytes can follow every cycle while out_if.ready is high.
// Reset (rst_n low, synchronous) empties both registers, sets check_path to 1
// and leaves the parser idle until a byte flagged with start_line arrives.
// With out_if.ready low the result register holds, the input register fills
// behind it and in_if.ready falls; no result is lost or repeated.
`default_nettype none

module http_request_line_parser_top
  import hrlp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  hrlp_in_if.sink   in_if,
  hrlp_out_if.source out_if,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_ready_int;
  logic    advance;
  result_t core_result;
  result_t out_result;

  // Pack the incoming transfer into the item type.
  assign in_item.data_byte  = in_if.data_byte;
  assign in_item.start_line = in_if.start_line;

  hrlp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_if.valid),
    .up_ready   (in_if.ready),
    .up_item    (in_item),
    .down_valid (stage_valid),
    .down_ready (out_ready_int),
    .down_item  (stage_item)
  );

  // The parser state moves only when the held byte really passes into the
  // result register, so a stall never advances the state twice.
  assign advance = stage_valid && out_ready_int;

  hrlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (stage_item),
    .result    (core_result)
  );

  hrlp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (stage_valid),
    .up_ready    (out_ready_int),
    .up_result   (core_result),
    .down_valid  (out_if.valid),
    .down_ready  (out_if.ready),
    .down_result (out_result)
  );

  // Unpack the registered result onto the outgoing channel.
  assign out_if.path_valid = out_result.path_valid;
  assign out_if.path_byte  = out_result.path_byte;
  assign out_if.done_res   = out_result.done_res;
  assign out_if.status     = out_result.status;
  assign out_if.method     = out_result.method;
  assign out_if.version    = out_result.version;

endmodule

`default_nettype wire

// ----- hdl/hrlp_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
// Depends on hrlp_pkg.
`default_nettype none

module hrlp_in_stage
  import hrlp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire item_t up_item,
  output logic       down_valid,
  input  wire logic  down_ready,
  output item_t      down_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign up_ready   = !valid_r || down_ready;
  assign down_valid = valid_r;
  assign down_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hrlp_core.sv -----
// Parser state machine and the check_path register; decodes one byte per
// advance into a result. Depends on hrlp_pkg.
`default_nettype none

module hrlp_core
  import hrlp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  input  wire logic  advance,
  input  wire item_t item,
  output result_t    result
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       post_r, post_nxt;
  logic       check_path_r;

  // State as seen by this byte, after a start flag has restarted the line.
  phase_t     eff_phase;
  logic [2:0] eff_pos;
  logic       eff_post;
  logic [2:0] method_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= 3'd0;
      post_r       <= 1'b0;
      check_path_r <= 1'b1;
    end else begin
      if (advance) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        post_r  <= post_nxt;
      end
      if (cfg_we) begin
        check_path_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    if (item.start_line) begin
      eff_phase = PH_METHOD;
      eff_pos   = 3'd0;
      eff_post  = 1'b0;
    end else begin
      eff_phase = phase_r;
      eff_pos   = pos_r;
      eff_post  = post_r;
    end
    method_last = eff_post ? POST_LAST : GET_LAST;
  end

  always_comb begin
    phase_nxt = eff_phase;
    pos_nxt   = eff_pos;
    post_nxt  = eff_post;
    result    = '0;

    unique case (eff_phase)
      PH_METHOD: begin
        if (eff_pos == 3'd0) begin
          if (item.data_byte == CH_G) begin
            post_nxt = 1'b0;
            pos_nxt  = 3'd1;
          end else if (item.data_byte == CH_P) begin
            post_nxt = 1'b1;
            pos_nxt  = 3'd1;
          end else begin
            post_nxt        = 1'b0;
            result.done_res = 1'b1;
            result.status   = ST_BAD_METHOD;
            phase_nxt       = PH_DONE;
          end
        end else if (eff_pos > method_last ||
                     item.data_byte != method_char(eff_post, eff_pos)) begin
          result.done_res = 1'b1;
          result.status   = ST_BAD_METHOD;
          phase_nxt       = PH_DONE;
        end else if (eff_pos == method_last) begin
          phase_nxt = PH_PATH_FIRST;
          pos_nxt   = 3'd0;
        end else begin
          pos_nxt = 3'(eff_pos + 3'd1);
        end
      end
      PH_PATH_FIRST: begin
        if (item.data_byte == CH_SPACE) begin
          if (check_path_r) begin
            result.done_res = 1'b1;
            result.status   = ST_BAD_PATH;
            phase_nxt       = PH_DONE;
          end else begin
            phase_nxt = PH_VERSION;
            pos_nxt   = 3'd0;
          end
        end else if (check_path_r && item.data_byte != CH_SLASH) begin
          result.done_res = 1'b1;
          result.status   = ST_BAD_PATH;
          phase_nxt       = PH_DONE;
        end else begin
          result.path_valid = 1'b1;
          result.path_byte  = item.data_byte;
          phase_nxt         = PH_PATH;
        end
      end
      PH_PATH: begin
        if (item.data_byte == CH_SPACE) begin
          phase_nxt = PH_VERSION;
          pos_nxt   = 3'd0;
        end else begin
          result.path_valid = 1'b1;
          result.path_byte  = item.data_byte;
        end
      end
      PH_VERSION: begin
        if (eff_pos < VER_PREFIX_LEN) begin
          if (item.data_byte != ver_char(eff_pos)) begin
            result.done_res = 1'b1;
            result.status   = ST_BAD_VERSION;
            phase_nxt       = PH_DONE;
          end else begin
            pos_nxt = 3'(eff_pos + 3'd1);
          end
        end else begin
          result.done_res = 1'b1;
          phase_nxt       = PH_DONE;
          if (item.data_byte == CH_ONE) begin
            result.status = ST_OK;
          end else if (item.data_byte == CH_ZERO) begin
            result.status  = ST_OK;
            result.version = 1'b1;
          end else begin
            result.status = ST_BAD_VERSION;
          end
        end
      end
      default: begin
        // Idle, done and unused codes ignore the byte.
      end
    endcase

    result.method = post_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/hrlp_out_stage.sv -----
// Result register stage: holds one result until the sink takes it.
// Depends on hrlp_pkg.
`default_nettype none

module hrlp_out_stage
  import hrlp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire result_t up_result,
  output logic         down_valid,
  input  wire logic    down_ready,
  output result_t      down_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign up_ready    = !valid_r || down_ready;
  assign down_valid  = valid_r;
  assign down_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      result_r <= up_result;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hrlp_checker.sv -----
// Port-level assertions for the HTTP request line parser and the bind that
// attaches them. Depends on hrlp_pkg and http_request_line_parser_top_assert.svh.
`default_nettype none

`include "http_request_line_parser_top_assert.svh"

module hrlp_checker
  import hrlp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       path_valid,
  input wire logic [7:0] path_byte,
  input wire logic       done_res,
  input wire logic [1:0] status,
  input wire logic       version
);

  // A path byte never comes with the end of a line.
  `HRLP_ASSERT_NOW(a_path_not_done, out_valid && path_valid, !done_res, "path byte with done")
  // The path byte is zero whenever it carries no path character.
  `HRLP_ASSERT_NOW(a_path_byte_zero, out_valid && !path_valid, path_byte == 8'h00,
                   "path byte not zero")
  // Status and version stay zero until the line ends.
  `HRLP_ASSERT_NOW(a_quiet_until_done, out_valid && !done_res,
                   status == ST_OK && !version, "status or version without done")
  // HTTP/1.0 is reported only on a successful end of line.
  `HRLP_ASSERT_NOW(a_version_ok, out_valid && version, done_res && status == ST_OK,
                   "version flag without ok done")
  // A stalled result stays offered with the same contents.
  `HRLP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                    out_valid && $stable(path_byte) && $stable(status) && $stable(done_res),
                    "stalled result changed")

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .path_valid (out_if.path_valid),
  .path_byte  (out_if.path_byte),
  .done_res   (out_if.done_res),
  .status     (out_if.status),
  .version    (out_if.version)
);

`default_nettype wire
